FILE: src/brt_pkg.sv
`default_nettype none
package brt_pkg;
    localparam int unsigned VAL_W = 48;
    localparam int unsigned RNG_W = 47;
    localparam int unsigned TOL_W = 25;
    localparam int unsigned ROW_W = 12;
    localparam int unsigned NUM_W = 49;

    // Classified row handed from the front part to the divider and selector.
    typedef struct packed {
        logic                    use_row;
        logic                    to_lower;
        logic                    neg_num;
        logic [NUM_W-1:0]        num_mag;
        logic [VAL_W-1:0]        den;
        logic [ROW_W-1:0]        row;
        logic                    last;
        logic                    boxed;
        logic [RNG_W-1:0]        range;
    } t_job;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_DIV  = 2'd1,
        ST_DONE = 2'd2
    } t_state;
endpackage
`default_nettype wire

FILE: src/brt_front.sv
`default_nettype none
module brt_front
    import brt_pkg::*;
#(
    parameter int unsigned MAX_ROWS = 4096
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [TOL_W-1:0] i_tol,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire logic [VAL_W-1:0] i_a,
    input  wire logic [VAL_W-1:0] i_b,
    input  wire logic             i_hl,
    input  wire logic [VAL_W-1:0] i_l,
    input  wire logic             i_hu,
    input  wire logic [VAL_W-1:0] i_u,
    input  wire logic             i_inc,
    input  wire logic             i_boxed,
    input  wire logic [RNG_W-1:0] i_range,
    input  wire logic             i_last,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output t_job                  o_job
);
    localparam int unsigned CNT_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int unsigned QD = 2;

    logic [CNT_W-1:0] r_cnt, n_cnt;
    t_job             r_q [QD];
    logic             r_wp, r_rp;
    logic [1:0]       r_fill;
    t_job             w_job;
    logic             w_neg, w_pos, w_lo, w_elig;
    logic [VAL_W-1:0] w_mag;
    logic signed [NUM_W-1:0] w_num;
    logic             w_push, w_pop;
    logic [CNT_W-1:0] w_row_full;

    assign w_neg = i_a[VAL_W-1];
    assign w_mag = w_neg ? (~i_a + 1'b1) : i_a;
    assign w_pos = !w_neg && (i_a != '0);
    assign w_lo  = (i_inc == w_pos);
    assign w_elig = w_mag > {{(VAL_W-TOL_W){1'b0}}, i_tol};
    assign w_row_full = r_cnt;

    always_comb begin
        if (w_lo) begin
            w_num = {i_b[VAL_W-1], i_b} - {i_l[VAL_W-1], i_l};
        end else begin
            w_num = {i_u[VAL_W-1], i_u} - {i_b[VAL_W-1], i_b};
        end
        w_job.use_row  = w_elig && (w_lo ? i_hl : i_hu);
        w_job.to_lower = w_lo;
        w_job.neg_num  = w_num[NUM_W-1];
        w_job.num_mag  = w_num[NUM_W-1] ? (~w_num + 1'b1) : w_num;
        w_job.den      = w_mag;
        w_job.row      = ROW_W'({{ROW_W{1'b0}}, w_row_full});
        w_job.last     = i_last;
        w_job.boxed    = i_boxed;
        w_job.range    = i_range;
    end

    assign o_ready = (r_fill != 2'(QD));
    assign w_push  = i_valid && o_ready;
    assign o_valid = (r_fill != 2'd0);
    assign w_pop   = o_valid && i_ready;
    assign o_job   = r_q[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (w_push) begin
            n_cnt = i_last ? '0 : CNT_W'((CNT_W+1)'(r_cnt) + 1'b1) ;
            if (CNT_W'(MAX_ROWS - 1) == r_cnt && !i_last) begin
                n_cnt = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_job;
        end
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
            r_fill <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_fill <= r_fill + 2'(w_push) - 2'(w_pop);
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_fill <= 2'(QD))
        else $error("queue overfilled");
endmodule
`default_nettype wire

FILE: src/brt_back.sv
`default_nettype none
module brt_back
    import brt_pkg::*;
#(
    parameter int unsigned FRAC_BITS = 24
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire t_job             i_job,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic [61:0]           o_data
);
    localparam int unsigned STEPS = NUM_W + FRAC_BITS;
    localparam int unsigned SC_W  = $clog2(STEPS + 1);
    localparam int unsigned DV_W  = VAL_W + 1;
    localparam logic [VAL_W-1:0] MAX47 = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic [VAL_W-1:0] MINV  = {1'b1, {(VAL_W-1){1'b0}}};

    t_state r_st, n_st;
    t_job   r_job;
    logic [STEPS-1:0] r_dvd;
    logic [STEPS-1:0] r_quo;
    logic [DV_W-1:0]  r_rem;
    logic [SC_W-1:0]  r_step;
    logic             r_lf, r_uf;
    logic signed [VAL_W-1:0] r_lr, r_ur;
    logic [ROW_W-1:0] r_lrow, r_urow;
    logic             r_ov;
    logic [61:0]      r_out;

    logic [DV_W-1:0]  w_sh, w_sub;
    logic             w_ge;
    logic signed [VAL_W-1:0] w_ratio, w_best;
    logic             w_lw, w_uw, w_have, w_flip, w_tol, w_lf, w_uf;
    logic signed [VAL_W-1:0] w_lr, w_ur;
    logic [ROW_W-1:0] w_lrow, w_urow, w_prow;
    logic [STEPS-1:0] w_mag;

    assign w_sh  = {r_rem[DV_W-2:0], r_dvd[STEPS-1]};
    assign w_ge  = w_sh >= {1'b0, r_job.den};
    assign w_sub = w_ge ? (w_sh - {1'b0, r_job.den}) : w_sh;

    always_comb begin
        w_mag = r_quo;
        if (r_job.neg_num) begin
            if (w_mag > STEPS'(MINV)) begin
                w_ratio = MINV;
            end else begin
                w_ratio = VAL_W'(~w_mag + 1'b1);
            end
        end else if (w_mag > STEPS'(MAX47)) begin
            w_ratio = MAX47;
        end else begin
            w_ratio = VAL_W'(w_mag);
        end
        w_lf = r_lf; w_lr = r_lr; w_lrow = r_lrow;
        w_uf = r_uf; w_ur = r_ur; w_urow = r_urow;
        if (r_job.use_row && r_job.to_lower && (!r_lf || w_ratio < r_lr)) begin
            w_lf = 1'b1; w_lr = w_ratio; w_lrow = r_job.row;
        end
        if (r_job.use_row && !r_job.to_lower && (!r_uf || w_ratio < r_ur)) begin
            w_uf = 1'b1; w_ur = w_ratio; w_urow = r_job.row;
        end
        w_have = r_job.boxed;
        w_flip = r_job.boxed;
        w_tol  = 1'b0;
        w_best = r_job.boxed ? $signed({1'b0, r_job.range}) : '0;
        w_prow = '0;
        w_lw = w_lf && (!w_have || w_lr < w_best);
        if (w_lw) begin
            w_have = 1'b1; w_flip = 1'b0; w_best = w_lr; w_prow = w_lrow; w_tol = 1'b1;
        end
        w_uw = w_uf && (!w_have || w_ur < w_best);
        if (w_uw) begin
            w_have = 1'b1; w_flip = 1'b0; w_best = w_ur; w_prow = w_urow; w_tol = 1'b0;
        end
        if (w_best < 0) begin
            w_best = '0;
        end
    end

    always_comb begin
        n_st = r_st;
        case (r_st)
            ST_IDLE: if (i_valid) n_st = ST_DIV;
            ST_DIV:  if (r_step == '0) n_st = r_job.last ? ST_DONE : ST_IDLE;
            ST_DONE: if (i_ready) n_st = ST_IDLE;
            default: n_st = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ready = (r_st == ST_IDLE);
        o_valid = (r_st == ST_DONE);
        o_data  = r_out;
    end

    always_ff @(posedge i_clk) begin
        if (r_st == ST_IDLE && i_valid) begin
            r_job  <= i_job;
            r_dvd  <= {i_job.num_mag, {FRAC_BITS{1'b0}}};
            r_quo  <= '0;
            r_rem  <= '0;
        end else if (r_st == ST_DIV && r_step != '0) begin
            r_dvd <= {r_dvd[STEPS-2:0], 1'b0};
            r_rem <= w_sub;
            r_quo <= {r_quo[STEPS-2:0], w_ge};
        end
        if (r_st == ST_DIV && r_step == '0) begin
            r_out <= {w_best[RNG_W-1:0], w_tol, w_prow, w_flip, w_have};
        end
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
            r_step <= '0;
            r_lf <= 1'b0; r_uf <= 1'b0;
            r_lr <= '0; r_ur <= '0; r_lrow <= '0; r_urow <= '0;
            r_ov <= 1'b0;
        end else begin
            r_st <= n_st;
            r_ov <= 1'b0;
            if (r_st == ST_IDLE && i_valid) begin
                r_step <= SC_W'(STEPS);
            end else if (r_st == ST_DIV && r_step != '0) begin
                r_step <= r_step - 1'b1;
            end
            if (r_st == ST_DIV && r_step == '0) begin
                if (r_job.last) begin
                    r_lf <= 1'b0; r_uf <= 1'b0;
                    r_lr <= '0; r_ur <= '0; r_lrow <= '0; r_urow <= '0;
                end else begin
                    r_lf <= w_lf; r_uf <= w_uf;
                    r_lr <= w_lr; r_ur <= w_ur; r_lrow <= w_lrow; r_urow <= w_urow;
                end
            end
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("result dropped");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("accepted row while result pending");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data[1] |-> o_data[0])
        else $error("flip without found");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) !r_ov)
        else $error("unexpected overflow flag");
endmodule
`default_nettype wire

FILE: src/bounded_ratio_test.sv
// Channel | Dir | Handshake            | Payload
// s_axis  | in  | tvalid/tready        | tdata row fields, tlast last_row
// m_axis  | out | tvalid/tready        | tdata result fields
// cfg     | in  | i_cfg_we             | pivot_tolerance
// Each row passes through the bit-serial divider, which takes no new row until it is done.
// The two-entry queue lets the next row be accepted while the divider works.
// A last row holds the divider until its result is taken.
// Reset is synchronous and clears all control state and the tolerance to one.
`default_nettype none
module bounded_ratio_test
    import brt_pkg::*;
#(
    parameter int unsigned MAX_ROWS  = 4096,
    parameter int unsigned FRAC_BITS = 24
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_we,
    input  wire logic [24:0]  i_cfg_data,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // column_element[47:0], basic_value[95:48], has_lower[96], lower_bound[144:97],
    // has_upper[145], upper_bound[193:146], entering_increasing[194],
    // entering_boxed[195], entering_range[242:196], zero pad [247:243]
    input  wire logic [247:0] s_axis_tdata,
    input  wire logic         s_axis_tlast,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // found[0], bound_flip[1], pivot_row[13:2], departing_to_lower[14],
    // min_ratio[61:15], zero pad [71:62]
    output logic [71:0]       m_axis_tdata
);
    logic [TOL_W-1:0] r_tol;
    logic             w_qv, w_qr;
    t_job             w_job;
    logic [61:0]      w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOL_W'(1);
        end else if (i_cfg_we) begin
            r_tol <= i_cfg_data;
        end
    end

    brt_front #(.MAX_ROWS(MAX_ROWS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_tol(r_tol),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_a(s_axis_tdata[47:0]), .i_b(s_axis_tdata[95:48]),
        .i_hl(s_axis_tdata[96]), .i_l(s_axis_tdata[144:97]),
        .i_hu(s_axis_tdata[145]), .i_u(s_axis_tdata[193:146]),
        .i_inc(s_axis_tdata[194]), .i_boxed(s_axis_tdata[195]),
        .i_range(s_axis_tdata[242:196]), .i_last(s_axis_tlast),
        .o_valid(w_qv), .i_ready(w_qr), .o_job(w_job)
    );

    brt_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(w_qv), .o_ready(w_qr), .i_job(w_job),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_data(w_res)
    );

    assign m_axis_tdata = {10'd0, w_res};
endmodule
`default_nettype wire
